### src/hsv_pkg.sv
// Shared types and widths for the HSV to RGB converter.
// No dependencies; used by the front, the queue and the back end.
package hsv_pkg;

    localparam int FIELD_W = 16;
    localparam int SEXT_W  = 3;

    // Classified pixel as it waits between front and back end
    typedef struct packed {
        logic                grey;
        logic [SEXT_W-1:0]   sextant;
        logic [FIELD_W-1:0]  frac;
        logic [FIELD_W-1:0]  saturation;
        logic [FIELD_W-1:0]  brightness;
    } t_item;

endpackage

### src/hsv_front.sv
// Front end: takes input transactions, masks the channels and splits hue*6
// into sextant and fraction. Depends on hsv_pkg.
module hsv_front #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [hsv_pkg::FIELD_W-1:0]  i_hue,
    input  logic [hsv_pkg::FIELD_W-1:0]  i_saturation,
    input  logic [hsv_pkg::FIELD_W-1:0]  i_brightness,
    input  logic                         i_full,
    output logic                         o_push,
    output hsv_pkg::t_item               o_item
);
    import hsv_pkg::*;

    localparam int N = CHANNEL_BITS;

    logic [N-1:0] hue_m;
    logic [N-1:0] sat_m;
    logic [N-1:0] val_m;
    logic [N+2:0] h6;

    assign hue_m = i_hue[N-1:0];
    assign sat_m = i_saturation[N-1:0];
    assign val_m = i_brightness[N-1:0];

    // hue*6 as shift-and-add
    assign h6 = {1'b0, hue_m, 2'b00} + {2'b00, hue_m, 1'b0};

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    always_comb begin
        o_item.grey       = (sat_m == '0);
        o_item.sextant    = h6[N+2:N];
        o_item.frac       = FIELD_W'(h6[N-1:0]);
        o_item.saturation = FIELD_W'(sat_m);
        o_item.brightness = FIELD_W'(val_m);
    end

endmodule

### src/hsv_queue.sv
// Short FIFO between front and back end so that each side stalls on its own.
// Depends on hsv_pkg.
module hsv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsv_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_valid,
    output hsv_pkg::t_item  o_item,
    input  logic            i_pop
);
    import hsv_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### src/hsv_back.sv
// Back end: three-stage arithmetic pipeline forming p, q, t and routing them
// by sextant, ending in the output register. Depends on hsv_pkg.
module hsv_back #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hsv_pkg::t_item               i_item,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [hsv_pkg::FIELD_W-1:0]  o_red,
    output logic [hsv_pkg::FIELD_W-1:0]  o_green,
    output logic [hsv_pkg::FIELD_W-1:0]  o_blue
);
    import hsv_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam logic [N-1:0]     FULL    = {N{1'b1}};
    localparam logic [N:0]       HUE_ONE = {1'b1, {N{1'b0}}};
    localparam logic [2*N-1:0]   FULL_SM = {{N{1'b1}}, {N{1'b0}}};

    localparam logic [SEXT_W-1:0] SEXT_RED_YEL = 3'd0;
    localparam logic [SEXT_W-1:0] SEXT_YEL_GRN = 3'd1;
    localparam logic [SEXT_W-1:0] SEXT_GRN_CYA = 3'd2;
    localparam logic [SEXT_W-1:0] SEXT_CYA_BLU = 3'd3;
    localparam logic [SEXT_W-1:0] SEXT_BLU_MAG = 3'd4;

    // floor(x / (2^N - 1)) for x <= (2^N - 1)^2: fold the high half into the
    // low half, then a remainder of at most 2M leaves a correction of 0..2.
    function automatic logic [N-1:0] div_full(input logic [2*N-1:0] x);
        logic [N:0]   y;
        logic [N-1:0] hi;
        logic [1:0]   c;
        begin
            hi = x[2*N-1:N];
            y  = {1'b0, hi} + {1'b0, x[N-1:0]};
            if (y >= {FULL, 1'b0}) begin
                c = 2'd2;
            end else if (y >= {1'b0, FULL}) begin
                c = 2'd1;
            end else begin
                c = 2'd0;
            end
            div_full = hi + N'(c);
        end
    endfunction

    // pipeline control
    logic en1, en2, en3;
    logic r1_valid, r2_valid, r_out_valid;

    // stage 1
    logic              r1_grey;
    logic [SEXT_W-1:0] r1_sext;
    logic [N-1:0]      r1_val;
    logic [2*N-1:0]    r1_fs, r1_gs, r1_ps;
    logic [N-1:0]      f_in, s_in, v_in;
    logic [N:0]        f_cmp;
    logic [2*N:0]      gs_full;

    // stage 2
    logic              r2_grey;
    logic [SEXT_W-1:0] r2_sext;
    logic [N-1:0]      r2_val;
    logic [N-1:0]      r2_p;
    logic [2*N-1:0]    r2_xq, r2_xt;
    logic [2*N-1:0]    zq, zt;
    logic [3*N-1:0]    xq, xt;

    // stage 3
    logic [N-1:0]      qv, tv;
    logic [N-1:0]      n_red, n_green, n_blue;
    logic [FIELD_W-1:0] r_red, r_green, r_blue;

    assign en3     = !r_out_valid || i_tready;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1;

    assign f_in    = i_item.frac[N-1:0];
    assign s_in    = i_item.saturation[N-1:0];
    assign v_in    = i_item.brightness[N-1:0];
    assign f_cmp   = HUE_ONE - {1'b0, f_in};
    assign gs_full = {{N{1'b0}}, f_cmp} * {{(N+1){1'b0}}, s_in};

    assign zq = FULL_SM - r1_fs;
    assign zt = FULL_SM - r1_gs;
    assign xq = {{(2*N){1'b0}}, r1_val} * {{N{1'b0}}, zq};
    assign xt = {{(2*N){1'b0}}, r1_val} * {{N{1'b0}}, zt};

    assign qv = div_full(r2_xq);
    assign tv = div_full(r2_xt);

    always_comb begin
        if (r2_grey) begin
            n_red   = r2_val;
            n_green = r2_val;
            n_blue  = r2_val;
        end else begin
            case (r2_sext)
                SEXT_RED_YEL: begin
                    n_red = r2_val; n_green = tv;     n_blue = r2_p;
                end
                SEXT_YEL_GRN: begin
                    n_red = qv;     n_green = r2_val; n_blue = r2_p;
                end
                SEXT_GRN_CYA: begin
                    n_red = r2_p;   n_green = r2_val; n_blue = tv;
                end
                SEXT_CYA_BLU: begin
                    n_red = r2_p;   n_green = qv;     n_blue = r2_val;
                end
                SEXT_BLU_MAG: begin
                    n_red = tv;     n_green = r2_p;   n_blue = r2_val;
                end
                default: begin
                    n_red = r2_val; n_green = r2_p;   n_blue = qv;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r_out_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_grey <= i_item.grey;
            r1_sext <= i_item.sextant;
            r1_val  <= v_in;
            r1_fs   <= {{N{1'b0}}, f_in} * {{N{1'b0}}, s_in};
            r1_gs   <= gs_full[2*N-1:0];
            r1_ps   <= {{N{1'b0}}, v_in} * {{N{1'b0}}, FULL - s_in};
        end
        if (en2) begin
            r2_grey <= r1_grey;
            r2_sext <= r1_sext;
            r2_val  <= r1_val;
            r2_p    <= div_full(r1_ps);
            // divide by 2^N here, by 2^N - 1 in the next stage
            r2_xq   <= xq[3*N-1:N];
            r2_xt   <= xt[3*N-1:N];
        end
        if (en3) begin
            r_red   <= FIELD_W'(n_red);
            r_green <= FIELD_W'(n_green);
            r_blue  <= FIELD_W'(n_blue);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

endmodule

### src/hsv_to_rgb_converter_top.sv
// HSV to RGB converter, one pixel per transaction, one pixel per clock sustained while
// m_axis_tready stays high. Path to the output transaction: queue write, then 3 pipeline
// stages, all registered; throughput 1/cycle when the output is not stalled.
// Queue of 4 entries lets the front keep accepting, until it fills, while output stalls.
// Synchronous active-low reset empties the queue and clears all valid flags.
// Depends on hsv_pkg, hsv_front, hsv_queue and hsv_back.
module hsv_to_rgb_converter_top #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // hue[15:0], saturation[31:16], brightness[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // red[15:0], green[31:16], blue[47:32]
);
    import hsv_pkg::*;

    logic                push;
    logic                full;
    logic                q_valid;
    logic                back_ready;
    t_item               front_item;
    t_item               q_item;
    logic [FIELD_W-1:0]  red, green, blue;

    hsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_hue        (s_axis_tdata[15:0]),
        .i_saturation (s_axis_tdata[31:16]),
        .i_brightness (s_axis_tdata[47:32]),
        .i_full       (full),
        .o_push       (push),
        .o_item       (front_item)
    );

    hsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (back_ready)
    );

    hsv_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (back_ready),
        .i_item   (q_item),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_red    (red),
        .o_green  (green),
        .o_blue   (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule
